// ----- sv/pnm_pkg.sv -----
// shared types and constants for the netpbm stream decoder
// no dependencies

package pnm_pkg;

   localparam int MAX_WIDTH   = 16384;
   localparam int MAX_HEIGHT  = 16384;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int DIV_STEPS   = 24;
   localparam int DCNT_W      = $clog2(DIV_STEPS);

   localparam logic [15:0] SAT_LIMIT = 16'hFFFF;
   localparam logic [7:0]  CHAR_P    = 8'h50;
   localparam logic [7:0]  CHAR_HASH = 8'h23;
   localparam logic [7:0]  CHAR_ZERO = 8'h30;
   localparam logic [7:0]  CHAR_ONE  = 8'h31;
   localparam logic [7:0]  CHAR_SIX  = 8'h36;
   localparam logic [7:0]  CHAR_NINE = 8'h39;
   localparam logic [7:0]  CHAR_SP   = 8'h20;
   localparam logic [7:0]  CHAR_TAB  = 8'h09;
   localparam logic [7:0]  CHAR_LF   = 8'h0A;
   localparam logic [7:0]  CHAR_CR   = 8'h0D;

   typedef enum logic [3:0] {
      PH_IDLE, PH_MAGIC_P, PH_MAGIC_N, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
      PH_ASCII, PH_BIN, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_POP, ST_DISPATCH, ST_NUM, ST_COMPLETE, ST_SAMPLE, ST_SCALE, ST_WAIT,
      ST_PUT, ST_PBM, ST_END, ST_FIN, ST_FLUSH
   } step_type;

   typedef enum logic [1:0] {KIND_PIXEL, KIND_HEADER, KIND_ERROR, KIND_TRUNC} kind_type;

   typedef enum logic [1:0] {RET_END, RET_NUM, RET_FIN} ret_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic       last;
      logic       is_digit;
      logic       is_space;
      logic       is_eol;
      logic       is_hash;
   } byte_type;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] x;
      logic [13:0] y;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [14:0] w;
      logic [14:0] h;
      logic [2:0]  fmt;
      logic        last_of_image;
      logic        last_in_run;
   } result_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quotient;
   } div_rsp_type;

endpackage

// ----- sv/pnm_front.sv -----
// front part: accepts file bytes, classifies them and queues them
// depends on pnm_pkg

module pnm_front
   import pnm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       req_tlast,
   output logic       q_valid,
   output byte_type   q_head,
   input  logic       q_pop
);

   byte_type                entry_ff [QUEUE_DEPTH];
   byte_type                cls;
   logic [QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]         count_ff, count_in;
   logic                    push;
   logic                    pop;

   always_comb begin
      cls.data     = req_tdata;
      cls.start    = req_tuser;
      cls.last     = req_tlast;
      cls.is_digit = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      cls.is_space = (req_tdata == CHAR_SP) || (req_tdata == CHAR_TAB) ||
                     (req_tdata == CHAR_LF) || (req_tdata == CHAR_CR);
      cls.is_eol   = (req_tdata == CHAR_LF) || (req_tdata == CHAR_CR);
      cls.is_hash  = (req_tdata == CHAR_HASH);
   end

   assign req_tready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_head     = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= cls;
      end
   end

endmodule

// ----- sv/pnm_div.sv -----
// restoring divider, one quotient bit per cycle, for sample scaling
// depends on pnm_pkg

module pnm_div
   import pnm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [23:0]       num_ff, num_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       den_ff, den_in;
   logic [16:0]       rsh;
   logic [16:0]       diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      rsh     = {rem_ff, num_ff[23]};
      diff    = rsh - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_STEPS - 1);
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         if (rsh >= {1'b0, den_ff}) begin
            rem_in = diff[15:0];
            num_in = {num_ff[22:0], 1'b1};
         end else begin
            rem_in = rsh[15:0];
            num_in = {num_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff[7:0];

endmodule

// ----- sv/pnm_back.sv -----
// back part: header parser, sample assembly and pixel sequencer with output register
// depends on pnm_pkg; uses pnm_div through the div request and response structs

module pnm_back
   import pnm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  byte_type    q_head,
   output logic        q_pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        out_valid,
   output result_type  out_res,
   input  logic        out_ready
);

   step_type    step_ff, step_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  fmt_ff, fmt_in;
   logic [14:0] width_ff, width_in, height_ff, height_in;
   logic [15:0] maxv_ff, maxv_in, accum_ff, accum_in;
   logic        ds_ff, ds_in, cmt_ff, cmt_in, lbn_ff, lbn_in;
   logic [13:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]  ci_ff, ci_in, sidx_ff, sidx_in;
   logic [7:0]  hi_ff, hi_in;
   logic [15:0] red_ff, red_in, green_ff, green_in, sample_ff, sample_in;
   byte_type    cur_ff, cur_in;
   ret_type     ret_ff, ret_in;
   logic [7:0]  r8_ff, r8_in, g8_ff, g8_in, b8_ff, b8_in;
   logic [3:0]  pbm_n_ff, pbm_n_in, pbm_i_ff, pbm_i_in;
   logic        pend_valid_ff, pend_valid_in, out_valid_ff, out_valid_in;
   result_type  pend_ff, pend_in, out_ff, out_in;

   logic        out_free, emit_ok, emit_req, do_put, rgb, bypass, sc_store;
   kind_type    emit_kind;
   logic [7:0]  put_r, put_g, put_b, sc_val;
   logic [15:0] operand;
   logic [19:0] acc_tmp;
   logic [14:0] col_nx, row_nx, pbm_diff;
   logic        col_wrap, row_wrap;
   step_type    step_true, step_false;
   result_type  emit_res;

   assign out_free = !out_valid_ff || out_ready;
   assign emit_ok  = !pend_valid_ff || out_free;
   assign rgb      = (fmt_ff == 3'd3) || (fmt_ff == 3'd6);
   assign bypass   = (maxv_ff == 16'd0) || (maxv_ff == 16'd255);
   assign col_nx   = {1'b0, col_ff} + 15'd1;
   assign row_nx   = {1'b0, row_ff} + 15'd1;
   assign col_wrap = (col_nx >= width_ff);
   assign row_wrap = (row_nx >= height_ff);
   assign acc_tmp  = 20'(accum_ff) * 20'd10 + 20'(cur_ff.data - CHAR_ZERO);
   assign pbm_diff = width_ff - {1'b0, col_ff};

   always_comb begin
      unique case (sidx_ff)
         2'd0:    operand = rgb ? red_ff : sample_ff;
         2'd1:    operand = green_ff;
         default: operand = sample_ff;
      endcase
      step_true  = (ret_ff == RET_NUM) ? ST_NUM : ((ret_ff == RET_FIN) ? ST_FIN : ST_END);
      step_false = (ret_ff == RET_FIN) ? ST_FIN : ST_END;
   end

   always_comb begin
      step_in       = step_ff;
      phase_in      = phase_ff;
      fmt_in        = fmt_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      maxv_in       = maxv_ff;
      accum_in      = accum_ff;
      ds_in         = ds_ff;
      cmt_in        = cmt_ff;
      lbn_in        = lbn_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      ci_in         = ci_ff;
      sidx_in       = sidx_ff;
      hi_in         = hi_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      sample_in     = sample_ff;
      cur_in        = cur_ff;
      ret_in        = ret_ff;
      r8_in         = r8_ff;
      g8_in         = g8_ff;
      b8_in         = b8_ff;
      pbm_n_in      = pbm_n_ff;
      pbm_i_in      = pbm_i_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !out_ready;
      out_in        = out_ff;
      q_pop         = 1'b0;
      emit_req      = 1'b0;
      emit_kind     = KIND_PIXEL;
      do_put        = 1'b0;
      put_r         = '0;
      put_g         = '0;
      put_b         = '0;
      sc_store      = 1'b0;
      sc_val        = '0;
      div_req.start    = 1'b0;
      div_req.dividend = {operand, 8'h00} - {8'h00, operand};
      div_req.divisor  = maxv_ff;

      if (emit_ok || step_ff == ST_FLUSH) begin
         unique case (step_ff)
            ST_POP: begin
               if (q_valid) begin
                  q_pop  = 1'b1;
                  cur_in = q_head;
                  if (q_head.start) begin
                     fmt_in    = '0;
                     width_in  = '0;
                     height_in = '0;
                     maxv_in   = '0;
                     accum_in  = '0;
                     ds_in     = 1'b0;
                     cmt_in    = 1'b0;
                     col_in    = '0;
                     row_in    = '0;
                     ci_in     = '0;
                     hi_in     = '0;
                     red_in    = '0;
                     green_in  = '0;
                     lbn_in    = 1'b0;
                     phase_in  = PH_MAGIC_P;
                  end
                  step_in = ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               step_in = ST_END;
               unique case (phase_ff)
                  PH_MAGIC_P: begin
                     if (cur_ff.data == CHAR_P) begin
                        phase_in = PH_MAGIC_N;
                     end else begin
                        emit_req  = 1'b1;
                        emit_kind = KIND_ERROR;
                        phase_in  = PH_IDLE;
                     end
                  end
                  PH_MAGIC_N: begin
                     if (cur_ff.data >= CHAR_ONE && cur_ff.data <= CHAR_SIX) begin
                        fmt_in   = cur_ff.data[2:0];
                        accum_in = '0;
                        ds_in    = 1'b0;
                        cmt_in   = 1'b0;
                        phase_in = PH_WIDTH;
                     end else begin
                        emit_req  = 1'b1;
                        emit_kind = KIND_ERROR;
                        phase_in  = PH_IDLE;
                     end
                  end
                  PH_WIDTH, PH_HEIGHT, PH_MAXVAL: step_in = ST_NUM;
                  PH_ASCII: begin
                     if (fmt_ff != 3'd1) begin
                        step_in = ST_NUM;
                     end else if (cmt_ff) begin
                        if (cur_ff.is_eol) cmt_in = 1'b0;
                     end else if (cur_ff.is_space) begin
                        step_in = ST_END;
                     end else if (cur_ff.is_hash) begin
                        cmt_in = 1'b1;
                     end else begin
                        r8_in   = (cur_ff.data == CHAR_ONE) ? 8'h00 : 8'hFF;
                        g8_in   = r8_in;
                        b8_in   = r8_in;
                        ret_in  = RET_END;
                        step_in = ST_PUT;
                     end
                  end
                  PH_BIN: begin
                     if (fmt_ff == 3'd4) begin
                        pbm_n_in = (pbm_diff > 15'd8) ? 4'd8 : pbm_diff[3:0];
                        pbm_i_in = '0;
                        step_in  = ST_PBM;
                     end else if (maxv_ff > 16'd255) begin
                        if (!lbn_ff) begin
                           hi_in  = cur_ff.data;
                           lbn_in = 1'b1;
                        end else begin
                           lbn_in    = 1'b0;
                           sample_in = {hi_ff, cur_ff.data};
                           ret_in    = RET_END;
                           step_in   = ST_SAMPLE;
                        end
                     end else begin
                        sample_in = {8'h00, cur_ff.data};
                        ret_in    = RET_END;
                        step_in   = ST_SAMPLE;
                     end
                  end
                  default: step_in = ST_END;
               endcase
            end
            ST_NUM: begin
               step_in = ST_END;
               if (cmt_ff) begin
                  if (cur_ff.is_eol) cmt_in = 1'b0;
               end else if (cur_ff.is_digit) begin
                  accum_in = (acc_tmp > 20'(SAT_LIMIT)) ? SAT_LIMIT : acc_tmp[15:0];
                  ds_in    = 1'b1;
               end else if (ds_ff) begin
                  ret_in  = RET_NUM;
                  step_in = ST_COMPLETE;
               end else if (cur_ff.is_space) begin
                  step_in = ST_END;
               end else if (cur_ff.is_hash) begin
                  cmt_in = 1'b1;
               end else begin
                  emit_req  = 1'b1;
                  emit_kind = KIND_ERROR;
                  phase_in  = PH_IDLE;
               end
            end
            ST_COMPLETE: begin
               accum_in = '0;
               ds_in    = 1'b0;
               step_in  = step_false;
               unique case (phase_ff)
                  PH_WIDTH: begin
                     if (accum_ff == '0 || accum_ff > 16'(MAX_WIDTH)) begin
                        emit_req  = 1'b1;
                        emit_kind = KIND_ERROR;
                        phase_in  = PH_IDLE;
                     end else begin
                        width_in = accum_ff[14:0];
                        phase_in = PH_HEIGHT;
                        step_in  = step_true;
                     end
                  end
                  PH_HEIGHT: begin
                     if (accum_ff == '0 || accum_ff > 16'(MAX_HEIGHT)) begin
                        emit_req  = 1'b1;
                        emit_kind = KIND_ERROR;
                        phase_in  = PH_IDLE;
                     end else begin
                        height_in = accum_ff[14:0];
                        if (fmt_ff == 3'd1 || fmt_ff == 3'd4) begin
                           maxv_in   = 16'd1;
                           emit_req  = 1'b1;
                           emit_kind = KIND_HEADER;
                        end else begin
                           phase_in = PH_MAXVAL;
                           step_in  = step_true;
                        end
                     end
                  end
                  PH_MAXVAL: begin
                     if (accum_ff == '0) begin
                        emit_req  = 1'b1;
                        emit_kind = KIND_ERROR;
                        phase_in  = PH_IDLE;
                     end else begin
                        maxv_in   = accum_ff;
                        emit_req  = 1'b1;
                        emit_kind = KIND_HEADER;
                     end
                  end
                  PH_ASCII: begin
                     sample_in = accum_ff;
                     step_in   = ST_SAMPLE;
                  end
                  default: step_in = step_false;
               endcase
               if (emit_req && emit_kind == KIND_HEADER) begin
                  col_in   = '0;
                  row_in   = '0;
                  ci_in    = '0;
                  lbn_in   = 1'b0;
                  cmt_in   = 1'b0;
                  phase_in = (fmt_ff <= 3'd3) ? PH_ASCII : PH_BIN;
               end
            end
            ST_SAMPLE: begin
               sidx_in = '0;
               if (rgb && ci_ff == 2'd0) begin
                  red_in  = sample_ff;
                  ci_in   = 2'd1;
                  step_in = step_true;
               end else if (rgb && ci_ff == 2'd1) begin
                  green_in = sample_ff;
                  ci_in    = 2'd2;
                  step_in  = step_true;
               end else begin
                  ci_in   = '0;
                  step_in = ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (bypass) begin
                  sc_store = 1'b1;
                  sc_val   = operand[7:0];
               end else begin
                  div_req.start = 1'b1;
                  step_in       = ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (div_rsp.done) begin
                  sc_store = 1'b1;
                  sc_val   = div_rsp.quotient;
               end
            end
            ST_PUT: begin
               do_put = 1'b1;
               put_r  = r8_ff;
               put_g  = g8_ff;
               put_b  = b8_ff;
               if (ret_ff == RET_FIN) begin
                  step_in = ST_FIN;
               end else if (ret_ff == RET_NUM && !(col_wrap && row_wrap)) begin
                  step_in = ST_NUM;
               end else begin
                  step_in = ST_END;
               end
            end
            ST_PBM: begin
               do_put   = 1'b1;
               put_r    = cur_ff.data[3'd7 - pbm_i_ff[2:0]] ? 8'h00 : 8'hFF;
               put_g    = put_r;
               put_b    = put_r;
               pbm_i_in = pbm_i_ff + 4'd1;
               if (pbm_i_in == pbm_n_ff) step_in = ST_END;
            end
            ST_END: begin
               if (cur_ff.last) begin
                  if (ds_ff && (phase_ff == PH_WIDTH || phase_ff == PH_HEIGHT ||
                                phase_ff == PH_MAXVAL ||
                                (phase_ff == PH_ASCII && fmt_ff != 3'd1))) begin
                     ret_in  = RET_FIN;
                     step_in = ST_COMPLETE;
                  end else begin
                     step_in = ST_FIN;
                  end
               end else begin
                  step_in = ST_FLUSH;
               end
            end
            ST_FIN: begin
               if (phase_ff != PH_IDLE && phase_ff != PH_DONE) begin
                  emit_req  = 1'b1;
                  emit_kind = KIND_TRUNC;
               end
               phase_in = PH_IDLE;
               step_in  = ST_FLUSH;
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  step_in = ST_POP;
               end else if (out_free) begin
                  out_in             = pend_ff;
                  out_in.last_in_run = 1'b1;
                  out_valid_in       = 1'b1;
                  pend_valid_in      = 1'b0;
                  step_in            = ST_POP;
               end
            end
            default: step_in = ST_POP;
         endcase
      end

      if (sc_store) begin
         if (!rgb) begin
            r8_in = sc_val;
            g8_in = sc_val;
            b8_in = sc_val;
         end else begin
            unique case (sidx_ff)
               2'd0:    r8_in = sc_val;
               2'd1:    g8_in = sc_val;
               default: b8_in = sc_val;
            endcase
         end
         if (!rgb || sidx_ff == 2'd2) begin
            step_in = ST_PUT;
         end else begin
            sidx_in = sidx_ff + 2'd1;
            step_in = ST_SCALE;
         end
      end

      emit_res = '0;
      if (do_put) begin
         emit_req               = 1'b1;
         emit_kind              = KIND_PIXEL;
         emit_res.x             = col_ff;
         emit_res.y             = row_ff;
         emit_res.r             = put_r;
         emit_res.g             = put_g;
         emit_res.b             = put_b;
         emit_res.last_of_image = col_wrap && row_wrap;
         if (col_wrap) begin
            col_in = '0;
            row_in = row_nx[13:0];
            if (row_wrap) phase_in = PH_DONE;
         end else begin
            col_in = col_nx[13:0];
         end
      end
      emit_res.kind = emit_kind;
      emit_res.w    = width_in;
      emit_res.h    = height_in;
      emit_res.fmt  = fmt_in;

      if (emit_req) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_valid_in = 1'b1;
         end
         pend_in       = emit_res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_POP;
         phase_ff      <= PH_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         fmt_ff        <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         maxv_ff       <= '0;
         accum_ff      <= '0;
         ds_ff         <= 1'b0;
         cmt_ff        <= 1'b0;
         lbn_ff        <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         ci_ff         <= '0;
      end else begin
         step_ff       <= step_in;
         phase_ff      <= phase_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         fmt_ff        <= fmt_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         maxv_ff       <= maxv_in;
         accum_ff      <= accum_in;
         ds_ff         <= ds_in;
         cmt_ff        <= cmt_in;
         lbn_ff        <= lbn_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         ci_ff         <= ci_in;
      end
   end

   always_ff @(posedge clock) begin
      sidx_ff   <= sidx_in;
      hi_ff     <= hi_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      sample_ff <= sample_in;
      cur_ff    <= cur_in;
      ret_ff    <= ret_in;
      r8_ff     <= r8_in;
      g8_ff     <= g8_in;
      b8_ff     <= b8_in;
      pbm_n_ff  <= pbm_n_in;
      pbm_i_ff  <= pbm_i_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_ff;

endmodule

// ----- sv/netpbm_stream_decoder.sv -----
// netpbm stream decoder: bytes of a P1..P6 file in, header, error and pixel results out
// the req channel carries one file byte per transfer, tuser marks the first byte of a
// file and tlast the final byte of the stream
// the rsp channel carries one result per transfer; tuser holds the result kind and the
// last-pixel flag, tlast marks the last result caused by one input byte
// bytes pass through a four-entry queue into a sequencer that handles one byte at a
// time, so input is taken while the sequencer or the receiver is busy
// a plain byte passes through the pop, dispatch, end and flush steps of the sequencer, a
// number or p1 pixel byte also through a number or put step; a completed sample adds the
// sample and put steps, plus a scale step and a wait on the one-bit-per-cycle divider for
// each component scaled (three per colour pixel) or a scale step for each bypassed
// component, and a p4 byte passes through the pbm step once for each pixel it holds
// reset clears the queue, the sequencer and the output register; the decoder then
// waits for a byte marked as the first of a file
// when rsp_tready is low the output register and one pending result hold, the
// sequencer waits, and req_tready falls once the queue is full
// depends on pnm_pkg, pnm_front, pnm_div and pnm_back

module netpbm_stream_decoder
   import pnm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // start_of_image
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // pixel_x, pixel_y, red, green, blue, image_width,
                                    // image_height, format_number, zero fill
   output logic [2:0]  rsp_tuser,   // result_kind, last_of_image
   output logic        rsp_tlast
);

   logic        q_valid;
   byte_type    q_head;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  res;

   pnm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   pnm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pnm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .out_valid (rsp_tvalid),
      .out_res   (res),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {3'b000, res.fmt, res.h, res.w, res.b, res.g, res.r, res.y, res.x};
   assign rsp_tuser = {res.last_of_image, res.kind};
   assign rsp_tlast = res.last_in_run;

endmodule
